// File: hw/rtl/sta_pkg.sv
// shared constants, codes and types of the sarsa table agent
`default_nettype none

package sta_pkg;

   // fixed field widths
   localparam int IDX_BITS       = 7;
   localparam int REWARD_BITS    = 32;
   localparam int ACTION_BITS    = 2;
   localparam int ACTION_COUNT   = 4;
   localparam int DRAW_BITS      = 4;
   localparam int COEF_BITS      = 16;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // scaler works on this many magnitude bits per cycle
   localparam int CHUNK_BITS = 24;
   localparam int ROUND_HALF = 32768;

   // parameter defaults
   localparam int DEF_STATE_COUNT = 128;
   localparam int DEF_VALUE_BITS  = 32;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISCOUNT      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREEZE        = 2'd2;

   localparam logic [COEF_BITS-1:0] LEARNING_RATE_RESET = 16'd6554;
   localparam logic [COEF_BITS-1:0] DISCOUNT_RESET      = 16'd58982;

   localparam logic [DRAW_BITS-1:0] EXPLORE_DRAW = 4'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_CHOOSE,
      ST_GAMMA,
      ST_TARGET,
      ST_OLD,
      ST_ALPHA,
      ST_WRITE
   } sta_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/sta_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module sta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/sta_scale.sv
// iterative fixed-point scaler: value * coef / 2^16, rounded on the magnitude
`default_nettype none

module sta_scale #(
   parameter int VALUE_BITS = sta_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [VALUE_BITS:0]           value,
   input  wire logic        [sta_pkg::COEF_BITS-1:0] coef,
   output logic                                      done,
   output logic signed      [VALUE_BITS:0]           result
);

   localparam int MAG_BITS = VALUE_BITS + 1;
   localparam int CHUNK    = sta_pkg::CHUNK_BITS;
   localparam int KB       = sta_pkg::COEF_BITS;
   localparam int NCHUNK   = (MAG_BITS + CHUNK - 1) / CHUNK;
   localparam int PAD_BITS = NCHUNK * CHUNK;
   localparam int ACC_BITS = PAD_BITS + KB;
   localparam int CNT_BITS = $clog2(NCHUNK + 1);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic                      neg_ff;
   logic [KB-1:0]             coef_ff;
   logic [PAD_BITS-1:0]       mag_ff;
   logic [ACC_BITS-1:0]       acc_ff;
   logic [CNT_BITS-1:0]       cnt_ff;
   logic signed [MAG_BITS-1:0] res_ff;

   logic [MAG_BITS-1:0]       mag_abs;
   logic [CHUNK+KB-1:0]       prod;
   logic [ACC_BITS-1:0]       rounded;
   logic [MAG_BITS-1:0]       mag_p;

   assign mag_abs = value[MAG_BITS-1] ? (~value + 1'b1) : value;
   assign prod    = mag_ff[PAD_BITS-1 -: CHUNK] * coef_ff;
   assign rounded = (acc_ff + ACC_BITS'(sta_pkg::ROUND_HALF)) >> sta_pkg::FRAC_BITS;
   assign mag_p   = rounded[MAG_BITS-1:0];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
      end else if (run_ff && cnt_ff == '0) begin
         run_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         if (start) begin
            cnt_ff <= CNT_BITS'(NCHUNK);
         end else if (run_ff && cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (start) begin
         neg_ff  <= value[MAG_BITS-1];
         coef_ff <= coef;
         // magnitude zero-extended at the top so the product is not scaled
         mag_ff  <= PAD_BITS'(mag_abs);
         acc_ff  <= '0;
      end else if (run_ff && cnt_ff != '0) begin
         // most significant chunk first, shift-accumulate
         acc_ff <= (acc_ff << CHUNK) + ACC_BITS'(prod);
         mag_ff <= mag_ff << CHUNK;
      end else if (run_ff) begin
         res_ff <= neg_ff ? -$signed(mag_p) : $signed(mag_p);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sarsa_table_agent.sv
// top level of the tabular sarsa agent with epsilon-greedy action choice
//
// usage
// - command channel: a transaction is taken at a rising edge with start high and
//   busy low; req_command selects start episode, step or end episode
// - result channel: rsp_valid is high for exactly one cycle with
//   rsp_chosen_action; start and step give one result, end and the unused
//   command give none; the receiver cannot stall, so nothing waits here
// - csr port: learning rate, discount and freeze are written by index at any
//   edge with csr_write_enable high; write them only while busy is low
// - the action table sits in one ram (one read, one write port); every
//   multiplication goes through one iterative multiply unit, chunked at 24 bits
// sequence per command; each transaction is served alone, busy stays high until it is done
// - start: all four entries of the row are read into an argmax, then the result
//   is strobed; a step while frozen does the same and writes nothing back
// - step while learning: after the result, the discount scale, the target, the
//   old entry read, the learning-rate scale and the table write-back; end: the
//   same from the target on, with the reward alone as target and no result
// reset
// - after reset all STATE_COUNT*4 table entries (512 at the defaults) are cleared,
//   one entry per cycle, with busy high; csr writes still land
`default_nettype none

module sarsa_table_agent #(
   parameter int STATE_COUNT = sta_pkg::DEF_STATE_COUNT,
   parameter int VALUE_BITS  = sta_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // command channel
   input  wire logic                                      start,
   output logic                                           busy,
   input  wire logic        [1:0]                         req_command,
   input  wire logic        [sta_pkg::IDX_BITS-1:0]       req_state_index,
   input  wire logic signed [sta_pkg::REWARD_BITS-1:0]    req_reward,
   input  wire logic        [sta_pkg::DRAW_BITS-1:0]      req_random_draw,
   input  wire logic        [sta_pkg::ACTION_BITS-1:0]    req_random_action,
   // result channel
   output logic                                           rsp_valid,
   output logic             [sta_pkg::ACTION_BITS-1:0]    rsp_chosen_action,
   // csr write port
   input  wire logic                                      csr_write_enable,
   input  wire logic        [sta_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic        [sta_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int IDX_W      = sta_pkg::IDX_BITS;
   localparam int ACT_W      = sta_pkg::ACTION_BITS;
   localparam int KB         = sta_pkg::COEF_BITS;
   localparam int STATE_BITS = $clog2(STATE_COUNT);
   localparam int DEPTH      = STATE_COUNT * sta_pkg::ACTION_COUNT;
   localparam int ADDR_BITS  = STATE_BITS + ACT_W;
   localparam int MAG_BITS   = VALUE_BITS + 1;
   localparam int EXT_BITS   =
      (VALUE_BITS > sta_pkg::REWARD_BITS ? VALUE_BITS : sta_pkg::REWARD_BITS) + 2;

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic signed [EXT_BITS-1:0] VAL_MAX =
      {{(EXT_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [EXT_BITS-1:0] VAL_MIN =
      {{(EXT_BITS-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

   // sequencer
   sta_pkg::sta_state_type state_ff, state_in;

   // csr registers
   logic [KB-1:0] lrate_ff;
   logic [KB-1:0] disc_ff;
   logic          freeze_ff;

   // agent memory
   logic [STATE_BITS-1:0] last_state_ff;
   logic [ACT_W-1:0]      last_action_ff;

   // captured transaction
   logic [1:0]                    cmd_ff;
   logic [STATE_BITS-1:0]         st_ff;
   logic signed [VALUE_BITS-1:0]  rew_ff;
   logic                          expl_ff;
   logic [ACT_W-1:0]              ract_ff;

   // working registers
   logic [ADDR_BITS-1:0]          clr_cnt_ff;
   logic [2:0]                    col_ff;
   logic signed [VALUE_BITS-1:0]  best_val_ff;
   logic [ACT_W-1:0]              best_idx_ff;
   logic signed [VALUE_BITS-1:0]  exp_val_ff;
   logic [ACT_W-1:0]              act_ff;
   logic signed [VALUE_BITS-1:0]  tgt_ff;
   logic signed [VALUE_BITS-1:0]  old_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]              rsp_action_ff;

   // combinational
   logic                          accept;
   logic [STATE_BITS-1:0]         st_red;
   logic signed [VALUE_BITS-1:0]  rew_sat;
   logic signed [EXT_BITS-1:0]    rew_ext;
   logic                          explore;
   logic [ACT_W-1:0]              act_sel;
   logic signed [VALUE_BITS-1:0]  q_sel;
   logic [ACT_W-1:0]              dcol;
   logic [ADDR_BITS-1:0]          old_addr;
   logic signed [EXT_BITS-1:0]    add_a, add_b, sum_ext;
   logic signed [VALUE_BITS-1:0]  sat_val;
   logic signed [MAG_BITS-1:0]    diff;

   // ram and scaler hookup
   logic                          ram_we;
   logic [ADDR_BITS-1:0]          ram_waddr, ram_raddr;
   logic [VALUE_BITS-1:0]         ram_wdata, ram_rdata;
   logic signed [VALUE_BITS-1:0]  rd_val;
   logic                          scl_start, scl_done;
   logic signed [MAG_BITS-1:0]    scl_value, scl_result;
   logic [KB-1:0]                 scl_coef;

   sta_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sta_scale #(
      .VALUE_BITS (VALUE_BITS)
   ) u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scl_start),
      .value  (scl_value),
      .coef   (scl_coef),
      .done   (scl_done),
      .result (scl_result)
   );

   assign rd_val   = $signed(ram_rdata);
   assign old_addr = {last_state_ff, last_action_ff};
   assign dcol     = col_ff[ACT_W-1:0] - 1'b1;
   assign explore  = expl_ff && !freeze_ff;
   assign act_sel  = explore ? ract_ff : best_idx_ff;
   assign q_sel    = explore ? exp_val_ff : best_val_ff;
   assign diff     = {tgt_ff[VALUE_BITS-1], tgt_ff} - {rd_val[VALUE_BITS-1], rd_val};

   // state number modulo STATE_COUNT by conditional subtraction of shifted copies
   always_comb begin
      logic [IDX_W-1:0] r;
      r = req_state_index;
      for (int k = IDX_W - 1; k >= 0; k--) begin
         if (int'(r) >= (STATE_COUNT << k)) begin
            r = r - IDX_W'(STATE_COUNT << k);
         end
      end
      st_red = STATE_BITS'(r);
   end

   // reward clamp to the table range
   assign rew_ext = {{(EXT_BITS-sta_pkg::REWARD_BITS){req_reward[sta_pkg::REWARD_BITS-1]}},
                     req_reward};
   always_comb begin
      if (rew_ext > VAL_MAX) begin
         rew_sat = VAL_MAX[VALUE_BITS-1:0];
      end else if (rew_ext < VAL_MIN) begin
         rew_sat = VAL_MIN[VALUE_BITS-1:0];
      end else begin
         rew_sat = rew_ext[VALUE_BITS-1:0];
      end
   end

   // shared add and saturate
   always_comb begin
      if (state_ff == sta_pkg::ST_WRITE) begin
         add_a = {{(EXT_BITS-VALUE_BITS){old_ff[VALUE_BITS-1]}}, old_ff};
         add_b = {{(EXT_BITS-MAG_BITS){scl_result[MAG_BITS-1]}}, scl_result};
      end else begin
         add_a = {{(EXT_BITS-VALUE_BITS){rew_ff[VALUE_BITS-1]}}, rew_ff};
         add_b = (cmd_ff == sta_pkg::CMD_STEP)
               ? {{(EXT_BITS-MAG_BITS){scl_result[MAG_BITS-1]}}, scl_result}
               : '0;
      end
      sum_ext = add_a + add_b;
      if (sum_ext > VAL_MAX) begin
         sat_val = VAL_MAX[VALUE_BITS-1:0];
      end else if (sum_ext < VAL_MIN) begin
         sat_val = VAL_MIN[VALUE_BITS-1:0];
      end else begin
         sat_val = sum_ext[VALUE_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sta_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) state_in = sta_pkg::ST_IDLE;
         end
         sta_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  sta_pkg::CMD_START, sta_pkg::CMD_STEP: state_in = sta_pkg::ST_ROW;
                  sta_pkg::CMD_END:                      state_in = sta_pkg::ST_TARGET;
                  default:                               state_in = sta_pkg::ST_IDLE;
               endcase
            end
         end
         sta_pkg::ST_ROW: begin
            if (col_ff == 3'd4) state_in = sta_pkg::ST_CHOOSE;
         end
         sta_pkg::ST_CHOOSE: begin
            if (cmd_ff == sta_pkg::CMD_STEP && !freeze_ff) begin
               state_in = sta_pkg::ST_GAMMA;
            end else begin
               state_in = sta_pkg::ST_IDLE;
            end
         end
         sta_pkg::ST_GAMMA: begin
            if (scl_done) state_in = sta_pkg::ST_TARGET;
         end
         sta_pkg::ST_TARGET: state_in = sta_pkg::ST_OLD;
         sta_pkg::ST_OLD:    state_in = sta_pkg::ST_ALPHA;
         sta_pkg::ST_ALPHA: begin
            if (scl_done) state_in = sta_pkg::ST_WRITE;
         end
         sta_pkg::ST_WRITE:  state_in = sta_pkg::ST_IDLE;
         default:            state_in = sta_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy         = (state_ff != sta_pkg::ST_IDLE);
      accept       = start && !busy;
      ram_we       = 1'b0;
      ram_waddr    = old_addr;
      ram_wdata    = sat_val;
      ram_raddr    = old_addr;
      scl_start    = 1'b0;
      scl_value    = {q_sel[VALUE_BITS-1], q_sel};
      scl_coef     = disc_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         sta_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         sta_pkg::ST_ROW: begin
            ram_raddr = {st_ff, col_ff[ACT_W-1:0]};
         end
         sta_pkg::ST_CHOOSE: begin
            rsp_valid_in = 1'b1;
            scl_start    = (cmd_ff == sta_pkg::CMD_STEP) && !freeze_ff;
         end
         sta_pkg::ST_OLD: begin
            // old entry arrives now: start alpha * (target - old)
            scl_start = 1'b1;
            scl_value = diff;
            scl_coef  = lrate_ff;
         end
         sta_pkg::ST_WRITE: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sta_pkg::ST_CLEAR;
         clr_cnt_ff     <= '0;
         col_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         last_state_ff  <= '0;
         last_action_ff <= '0;
         lrate_ff       <= sta_pkg::LEARNING_RATE_RESET;
         disc_ff        <= sta_pkg::DISCOUNT_RESET;
         freeze_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == sta_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (accept) begin
            col_ff <= '0;
         end else if (state_ff == sta_pkg::ST_ROW) begin
            col_ff <= col_ff + 1'b1;
         end
         // start remembers at once, a learning step after its write-back
         if (state_ff == sta_pkg::ST_CHOOSE && cmd_ff == sta_pkg::CMD_START) begin
            last_state_ff  <= st_ff;
            last_action_ff <= act_sel;
         end else if (state_ff == sta_pkg::ST_WRITE && cmd_ff == sta_pkg::CMD_STEP) begin
            last_state_ff  <= st_ff;
            last_action_ff <= act_ff;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               sta_pkg::CSR_LEARNING_RATE: lrate_ff  <= csr_write_data;
               sta_pkg::CSR_DISCOUNT:      disc_ff   <= csr_write_data;
               sta_pkg::CSR_FREEZE:        freeze_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         st_ff   <= st_red;
         rew_ff  <= rew_sat;
         expl_ff <= (req_random_draw == sta_pkg::EXPLORE_DRAW);
         ract_ff <= req_random_action;
      end
      // argmax over the row as it streams out, ties keep the lower index
      if (state_ff == sta_pkg::ST_ROW && col_ff != '0) begin
         if (col_ff == 3'd1 || rd_val > best_val_ff) begin
            best_val_ff <= rd_val;
            best_idx_ff <= dcol;
         end
         if (dcol == ract_ff) begin
            exp_val_ff <= rd_val;
         end
      end
      if (state_ff == sta_pkg::ST_CHOOSE) begin
         act_ff        <= act_sel;
         rsp_action_ff <= act_sel;
      end
      if (state_ff == sta_pkg::ST_TARGET) begin
         tgt_ff <= sat_val;
      end
      if (state_ff == sta_pkg::ST_OLD) begin
         old_ff <= rd_val;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_action = rsp_action_ff;

   // checks
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cmd_ff == sta_pkg::CMD_START || cmd_ff == sta_pkg::CMD_STEP))
      else $error("result from a command that gives none");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sta_pkg::ST_CLEAR) |-> (ram_we && ram_wdata == '0))
      else $error("clearing pass writes a nonzero entry");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == sta_pkg::CMD_START || req_command == sta_pkg::CMD_STEP
                  || req_command == sta_pkg::CMD_END)) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_write_learning: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sta_pkg::ST_WRITE) |-> (cmd_ff == sta_pkg::CMD_END
                                           || (cmd_ff == sta_pkg::CMD_STEP && !freeze_ff)))
      else $error("table write-back outside a learning transaction");

endmodule

`default_nettype wire
